### src/rfp_pkg.sv
// Shared types and constants for the relocation fixup patcher.
package rfp_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned INDEX_W = 22;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISPLACEMENT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_OFFSET = 2'd2;

  localparam logic [3:0] TYPE_HIGH = 4'd1;
  localparam logic [3:0] TYPE_LOW = 4'd2;
  localparam logic [3:0] TYPE_HIGHLOW = 4'd3;
  localparam logic [3:0] TYPE_HIGHADJ = 4'd4;
  localparam logic [3:0] TYPE_SPLIT = 4'd5;
  localparam logic [3:0] TYPE_MARK16 = 4'd6;
  localparam logic [3:0] TYPE_MARK32 = 4'd9;
  localparam logic [3:0] TYPE_DIR64 = 4'd10;
  localparam logic [3:0] TYPE_TRAP = 4'd11;

  localparam logic [15:0] MARK16_WORD = 16'hA000;
  localparam logic [31:0] MARK32_WORD = 32'hFA00_0000;
  localparam logic [6:0] PAIR_MARK = 7'h7F;

  localparam logic [1:0] SIZE_NONE = 2'd0;
  localparam logic [1:0] SIZE_TWO = 2'd1;
  localparam logic [1:0] SIZE_FOUR = 2'd2;
  localparam logic [1:0] SIZE_EIGHT = 2'd3;

  typedef enum logic [3:0] {
    KIND_NONE,
    KIND_ADD16_HI,
    KIND_ADD16_LO,
    KIND_ADD32_LO,
    KIND_ADD32_HI,
    KIND_SPLIT_ONE,
    KIND_SPLIT_PAIR,
    KIND_MARK16,
    KIND_MARK32,
    KIND_ADD64,
    KIND_TRAP
  } fix_kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0] image_address;
    logic [DATA_W-1:0] displacement;
    logic [INDEX_W-1:0] index_offset;
  } rfp_config_t;

  typedef struct packed {
    logic [ADDR_W-1:0] target_address;
    logic [DATA_W-1:0] old_data;
    fix_kind_t kind;
    logic last;
  } rfp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rfp_queue_status_t;

endpackage

### src/relocation_fixup_patcher_core.sv
// Top level of the relocation fixup patcher: configuration registers and the two halves.
// Each request is one base-relocation entry together with the eight bytes now at its
// target; each gives exactly one result with the target address, the patched bytes,
// the write size and a trap flag. One request is taken per clock while in_stall is low.
// A request is classified and written into a queue slot, then patched in the patch unit,
// which ends in the result register. The queue of QUEUE_DEPTH requests lets the front
// keep accepting while the result side is stalled. Configuration writes take effect at
// once and belong to idle periods.
module relocation_fixup_patcher_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] page_offset,
  input  logic [15:0] entry_tag,
  input  logic [63:0] old_data,
  input  logic        last_entry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] target_address,
  output logic [63:0] new_data,
  output logic [1:0]  write_size,
  output logic        trap_request,
  output logic        last_result
);
  import rfp_pkg::*;

  rfp_config_t cfg;
  rfp_queue_status_t q_status;
  rfp_entry_t wr_entry;
  rfp_entry_t rd_entry;
  logic push;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_ADDRESS: cfg.image_address <= cfg_data;
        CFG_DISPLACEMENT: cfg.displacement <= cfg_data;
        CFG_INDEX_OFFSET: cfg.index_offset <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  rfp_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .page_offset(page_offset),
    .entry_tag  (entry_tag),
    .old_data   (old_data),
    .last_entry (last_entry),
    .cfg        (cfg),
    .q_status   (q_status),
    .push       (push),
    .entry      (wr_entry)
  );

  rfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_entry(wr_entry),
    .pop     (pop),
    .rd_entry(rd_entry),
    .status  (q_status)
  );

  rfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .rd_entry      (rd_entry),
    .pop           (pop),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .target_address(target_address),
    .new_data      (new_data),
    .write_size    (write_size),
    .trap_request  (trap_request),
    .last_result   (last_result)
  );

  a_trap_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trap_request && write_size != SIZE_NONE))
    else $error("trap result carries a write");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("queue written while full");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !q_status.empty)
    else $error("accepted request missing from queue");

endmodule

### src/rfp_front.sv
// Front end: accepts requests, forms the target address and classifies the fixup.
module rfp_front (
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                page_offset,
  input  logic [15:0]                entry_tag,
  input  logic [63:0]                old_data,
  input  logic                       last_entry,
  input  rfp_pkg::rfp_config_t       cfg,
  input  rfp_pkg::rfp_queue_status_t q_status,
  output logic                       push,
  output rfp_pkg::rfp_entry_t        entry
);
  import rfp_pkg::*;

  logic index_set;

  assign in_stall = q_status.full;
  assign push = in_valid && !q_status.full;
  assign index_set = cfg.index_offset != '0;

  always_comb begin
    entry.target_address = cfg.image_address + {32'd0, page_offset}
                           + {52'd0, entry_tag[11:0]};
    entry.old_data = old_data;
    entry.last = last_entry;
    unique case (entry_tag[15:12])
      TYPE_HIGH: entry.kind = KIND_ADD16_HI;
      TYPE_LOW: entry.kind = KIND_ADD16_LO;
      TYPE_HIGHLOW: entry.kind = KIND_ADD32_LO;
      TYPE_HIGHADJ: entry.kind = KIND_ADD32_HI;
      TYPE_SPLIT: begin
        entry.kind = (old_data[15:9] == PAIR_MARK) ? KIND_SPLIT_PAIR : KIND_SPLIT_ONE;
      end
      TYPE_MARK16: begin
        entry.kind = (old_data[15:0] == MARK16_WORD && index_set) ? KIND_MARK16 : KIND_NONE;
      end
      TYPE_MARK32: begin
        entry.kind = (old_data[31:0] == MARK32_WORD && index_set) ? KIND_MARK32 : KIND_NONE;
      end
      TYPE_DIR64: entry.kind = KIND_ADD64;
      TYPE_TRAP: entry.kind = KIND_TRAP;
      default: entry.kind = KIND_NONE;
    endcase
  end

endmodule

### src/rfp_queue.sv
// Small request queue between the front end and the patch unit.
module rfp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  rfp_pkg::rfp_entry_t        wr_entry,
  input  logic                       pop,
  output rfp_pkg::rfp_entry_t        rd_entry,
  output rfp_pkg::rfp_queue_status_t status
);
  import rfp_pkg::*;

  // DEPTH must be a power of two of at least two so the pointers wrap naturally.
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  rfp_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign rd_entry = slots[rd_ptr];
  assign status.full = count == FULL_COUNT;
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/rfp_back.sv
// Patch unit: applies the classified fixup and holds the result register.
module rfp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  rfp_pkg::rfp_queue_status_t q_status,
  input  rfp_pkg::rfp_entry_t        rd_entry,
  output logic                       pop,
  input  rfp_pkg::rfp_config_t       cfg,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [63:0]                target_address,
  output logic [63:0]                new_data,
  output logic [1:0]                 write_size,
  output logic                       trap_request,
  output logic                       last_result
);
  import rfp_pkg::*;

  logic [63:0] old;
  logic [63:0] disp;
  logic [21:0] neg_index;
  logic [24:0] one_sum;
  logic [24:0] hi_sum;
  logic [23:0] lo_sum;
  logic [63:0] data_next;
  logic [1:0] size_next;
  logic trap_next;

  assign pop = !q_status.empty && (!out_valid || !out_stall);
  assign old = rd_entry.old_data;
  assign disp = cfg.displacement;
  assign neg_index = ~cfg.index_offset + 22'd1;

  always_comb begin
    one_sum = {old[8:0], old[31:16]} + disp[24:0];
    hi_sum = {1'b0, old[39:32], old[63:48]} + {1'b0, disp[23:0]};
    lo_sum = {old[7:0], old[31:16]} + disp[47:24] + disp[47:24] + {23'd0, hi_sum[24]};
  end

  always_comb begin
    data_next = old;
    size_next = SIZE_NONE;
    trap_next = 1'b0;
    case (rd_entry.kind)
      KIND_ADD16_HI: begin
        data_next[15:0] = old[15:0] + disp[31:16];
        size_next = SIZE_TWO;
      end
      KIND_ADD16_LO: begin
        data_next[15:0] = old[15:0] + disp[15:0];
        size_next = SIZE_TWO;
      end
      KIND_ADD32_LO: begin
        data_next[31:0] = old[31:0] + disp[31:0];
        size_next = SIZE_FOUR;
      end
      KIND_ADD32_HI: begin
        data_next[31:0] = old[31:0] + disp[63:32];
        size_next = SIZE_FOUR;
      end
      KIND_SPLIT_ONE: begin
        data_next[31:0] = {one_sum[15:0], old[15:9], one_sum[24:16]};
        size_next = SIZE_FOUR;
      end
      KIND_SPLIT_PAIR: begin
        data_next = {hi_sum[15:0], old[47:40], hi_sum[23:16],
                     lo_sum[15:0], old[15:8], lo_sum[23:16]};
        size_next = SIZE_EIGHT;
      end
      KIND_MARK16: begin
        data_next[15:0] = old[15:0] | {3'd0, neg_index[9:0], 3'd0};
        size_next = SIZE_TWO;
      end
      KIND_MARK32: begin
        data_next[31:0] = old[31:0] | {7'd0, neg_index, 3'd0};
        size_next = SIZE_FOUR;
      end
      KIND_ADD64: begin
        data_next = old + disp;
        size_next = SIZE_EIGHT;
      end
      KIND_TRAP: trap_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      target_address <= rd_entry.target_address;
      new_data <= data_next;
      write_size <= size_next;
      trap_request <= trap_next;
      last_result <= rd_entry.last;
    end
  end

endmodule
